### rtl/core/vt4_pkg.sv
// vt4_pkg: shared types and constants for the 4x4 vertex transform block
// holds the item structs, the queue command format and the queue status bundle
// no dependencies
package vt4_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned MAT_N           = 16;
  localparam int unsigned IDX_W           = 4;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // item kinds as they arrive on the input channel
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_POINT = 2'd2
  } vt4_kind_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic [IDX_W-1:0]         element_index;
    logic signed [DATA_W-1:0] element_value;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
    logic signed [DATA_W-1:0] vec_w;
  } vt4_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic                     has_w;
  } vt4_out_t;

  // queue entry: a load carries its value in d0
  typedef struct packed {
    vt4_kind_e                op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] d0;
    logic signed [DATA_W-1:0] d1;
    logic signed [DATA_W-1:0] d2;
    logic signed [DATA_W-1:0] d3;
  } vt4_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vt4_qstat_t;

endpackage

### rtl/core/vt4_front.sv
// vt4_front: accepts input items, drops unused kinds and builds queue commands
// depends on vt4_pkg
module vt4_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vt4_pkg::vt4_in_t    in_data_i,
  input  vt4_pkg::vt4_qstat_t qstat_i,
  output logic                push_o,
  output vt4_pkg::vt4_cmd_t   cmd_o
);
  import vt4_pkg::*;

  logic keep;

  // take items whenever the queue has room
  assign in_ready_o = !qstat_i.full;

  // classify the kind, unused codes are accepted and dropped
  always_comb begin
    keep   = 1'b0;
    cmd_o  = '0;
    cmd_o.idx = in_data_i.element_index;
    case (in_data_i.kind)
      KIND_LOAD: begin
        keep     = 1'b1;
        cmd_o.op = KIND_LOAD;
        cmd_o.d0 = in_data_i.element_value;
      end
      KIND_FULL, KIND_POINT: begin
        keep     = 1'b1;
        cmd_o.op = vt4_kind_e'(in_data_i.kind);
        cmd_o.d0 = in_data_i.vec_x;
        cmd_o.d1 = in_data_i.vec_y;
        cmd_o.d2 = in_data_i.vec_z;
        cmd_o.d3 = in_data_i.vec_w;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push_o = in_valid_i && in_ready_o && keep;

endmodule

### rtl/core/vt4_queue.sv
// vt4_queue: short command queue between the front and the back
// depends on vt4_pkg
module vt4_queue #(
  parameter int unsigned DEPTH = vt4_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vt4_pkg::vt4_cmd_t   cmd_i,
  input  logic                pop_i,
  output vt4_pkg::vt4_cmd_t   cmd_o,
  output vt4_pkg::vt4_qstat_t qstat_o
);
  import vt4_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  vt4_cmd_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o         = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

### rtl/core/vt4_back.sv
// vt4_back: matrix store and three-stage multiply, add and saturate pipeline
// depends on vt4_pkg
module vt4_back #(
  parameter int unsigned FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vt4_pkg::vt4_cmd_t   cmd_i,
  input  vt4_pkg::vt4_qstat_t qstat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vt4_pkg::vt4_out_t   out_data_o
);
  import vt4_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned TERM_W = PROD_W - FRAC_BITS;
  localparam int unsigned PAIR_W = TERM_W + 1;
  localparam int unsigned SUM_W  = TERM_W + 2;

  logic signed [DATA_W-1:0] mat_q [MAT_N];
  logic signed [DATA_W-1:0] vec [4];
  logic signed [TERM_W-1:0] term_d [4][4];
  logic signed [TERM_W-1:0] term_q [4][4];
  logic signed [PAIR_W-1:0] pair_d [4][2];
  logic signed [PAIR_W-1:0] pair_q [4][2];
  logic signed [DATA_W-1:0] res [4];
  logic                     v1_q, v2_q, w1_q, w2_q;
  logic                     out_valid_q;
  vt4_out_t                 out_q, out_d;
  logic                     adv, pop, is_load;

  // whole pipeline moves when the output register is free or being drained
  assign adv     = !out_valid_q || out_ready_i;
  assign pop     = adv && !qstat_i.empty;
  assign is_load = (cmd_i.op == KIND_LOAD);
  assign pop_o   = pop;

  // stage 1: sixteen products, shifted; point mode adds column 3 as is
  always_comb begin
    logic signed [PROD_W-1:0] prod;
    vec[0] = cmd_i.d0;
    vec[1] = cmd_i.d1;
    vec[2] = cmd_i.d2;
    vec[3] = cmd_i.d3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod = PROD_W'(mat_q[4*c+r]) * PROD_W'(vec[c]);
        if (c == 3 && cmd_i.op == KIND_POINT) begin
          term_d[r][c] = TERM_W'(mat_q[4*c+r]);
        end else begin
          term_d[r][c] = TERM_W'(prod >>> FRAC_BITS);
        end
      end
    end
  end

  // stage 2: pair sums per row
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      pair_d[r][0] = PAIR_W'(term_q[r][0]) + PAIR_W'(term_q[r][1]);
      pair_d[r][1] = PAIR_W'(term_q[r][2]) + PAIR_W'(term_q[r][3]);
    end
  end

  // stage 3: final sum and saturation to 32 bits
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic                    fits;
    for (int r = 0; r < 4; r++) begin
      sum  = SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]);
      fits = (&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]);
      if (fits) begin
        res[r] = sum[DATA_W-1:0];
      end else if (sum[SUM_W-1]) begin
        res[r] = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        res[r] = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
    out_d.out_x = res[0];
    out_d.out_y = res[1];
    out_d.out_z = res[2];
    out_d.out_w = w2_q ? res[3] : '0;
    out_d.has_w = w2_q;
  end

  // matrix store, loads take effect when they leave the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAT_N; i++) begin
        mat_q[i] <= '0;
      end
    end else if (pop && is_load) begin
      mat_q[cmd_i.idx] <= cmd_i.d0;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= pop && !is_load;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w1_q   <= (cmd_i.op == KIND_FULL);
      w2_q   <= w1_q;
      term_q <= term_d;
      pair_q <= pair_d;
      out_q  <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/vertex_transform_4x4_top.sv
// vertex_transform_4x4_top: top level of the 4x4 fixed-point vertex transform
// depends on vt4_pkg, vt4_front, vt4_queue and vt4_back
//
// Takes one item per clock cycle while the queue is not full: loads write one Q16.16
// matrix element, vector items come out as one result. The item enters the queue at
// the edge that takes it, then passes the multiply stage, the pair add stage and the
// final add and saturate into the output register. Sixteen 32x32 multipliers in the
// first stage set the rate of one vector per cycle while the output is taken. A short
// command queue sits between the front and the pipeline, so input keeps flowing for up
// to QUEUE_DEPTH items while a result waits to be taken; loads pass through the queue
// in order, so they only affect later vectors.
module vertex_transform_4x4_top #(
  parameter int unsigned FRAC_BITS   = vt4_pkg::FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = vt4_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vt4_pkg::vt4_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vt4_pkg::vt4_out_t out_data_o
);
  import vt4_pkg::*;

  vt4_cmd_t   push_cmd, head_cmd;
  vt4_qstat_t qstat;
  logic       push, pop;

  // front: accept and classify
  vt4_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // command queue
  vt4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .qstat_o (qstat)
  );

  // back: matrix and transform pipeline
  vt4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // point results carry a zero w
  a_point_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_w |-> out_data_o.out_w == '0)
    else $error("point result with nonzero w");

  // never pop an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // never push into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into full queue");

  // a queue cannot be full and empty at once
  a_qstat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty together");

endmodule
